// ===== rtl/core/sli_pkg.sv =====
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and constants for the sorted insertion list.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int unsigned DefDepth = 16;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned CountW   = 5;

  typedef enum logic [1:0] {
    ModeInsert  = 2'd0,
    ModeDelOne  = 2'd1,
    ModeDelAll  = 2'd2,
    ModeReadOut = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusFull     = 2'd1,
    StatusNotFound = 2'd2,
    StatusEmpty    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StDelAll,
    StRead
  } state_e;

  typedef enum logic [1:0] {
    CellHold,
    CellInsert,
    CellShift,
    CellRotate
  } cell_op_e;

  typedef struct packed {
    cell_op_e                  op;
    logic signed [ValueW-1:0]  value;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/sli_cell.sv =====
// ----------------------------------------------------------------------------
// sli_cell
// One list slot: holds an entry, compares it against the broadcast value and
// takes a neighbor's entry, the broadcast value or the head entry on insert, shift and rotate.
// ----------------------------------------------------------------------------
module sli_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 5
) (
  input  logic                                clk_i,
  input  sli_pkg::cell_ctrl_t                 ctrl_i,
  input  logic [CntW-1:0]                     count_i,
  input  logic                                gt_left_i,
  input  logic signed [sli_pkg::ValueW-1:0]   entry_left_i,
  input  logic signed [sli_pkg::ValueW-1:0]   entry_right_i,
  input  logic signed [sli_pkg::ValueW-1:0]   entry_head_i,
  output logic signed [sli_pkg::ValueW-1:0]   entry_o,
  output logic                                gt_o,
  output logic                                ge_o,
  output logic                                eq_o
);

  localparam logic [CntW-1:0] MyIdx  = CntW'(Idx);
  localparam logic [CntW-1:0] NextIdx = CntW'(Idx + 1);

  logic signed [sli_pkg::ValueW-1:0] entry_q, entry_d;
  logic valid, at_count, at_last, lt;

  assign valid    = count_i > MyIdx;
  assign at_count = count_i == MyIdx;
  assign at_last  = count_i == NextIdx;
  assign lt       = ctrl_i.value < entry_q;

  assign gt_o    = valid && lt;
  assign eq_o    = valid && (entry_q == ctrl_i.value);
  assign ge_o    = gt_o || eq_o;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      sli_pkg::CellInsert: begin
        if (gt_left_i) begin
          entry_d = entry_left_i;
        end else if (gt_o || at_count) begin
          entry_d = ctrl_i.value;
        end
      end
      sli_pkg::CellShift: begin
        if (ge_o) begin
          entry_d = entry_right_i;
        end
      end
      sli_pkg::CellRotate: begin
        if (at_last) begin
          entry_d = entry_head_i;
        end else if (valid) begin
          entry_d = entry_right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== rtl/core/sorted_list_insert_delete_core.sv =====
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_core
// Bounded ascending list of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Present mode_i and value_i with start high; the item is taken on a rising
//   edge where busy is low. Results appear on status_o, element_o, last_o and
//   count_o for one cycle each, flagged by result_valid_o, in the cycle after
//   the work that makes them. The receiver cannot stall the block.
// Timing:
//   Insert and delete-first need no busy state: every cell compares and shifts at
//   once, so busy stays low and a new item can follow each cycle.
//   Delete-all removes one match per cycle through the same shift path, with
//   busy high until no match is left.
//   Read-out rotates the row through cell 0, one entry per cycle, so a list
//   of n entries returns to its original order.
//   Read-out of an empty list gives one empty result.
// Reset:
//   rst_ni clears the count and the control state; the list is then empty.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_core #(
  parameter int unsigned DEPTH = sli_pkg::DefDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         mode_i,
  input  logic signed [sli_pkg::ValueW-1:0]  value_i,
  output logic                               result_valid_o,
  output logic [1:0]                         status_o,
  output logic signed [sli_pkg::ValueW-1:0]  element_o,
  output logic                               last_o,
  output logic [sli_pkg::CountW-1:0]         count_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] Full = CntW'(DEPTH);
  localparam logic [CntW-1:0] One  = CntW'(1);

  sli_pkg::state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d, rd_q, rd_d;
  logic signed [sli_pkg::ValueW-1:0] value_q, value_d;
  logic found_any_q, found_any_d;

  logic res_valid_q, res_valid_d, res_last_q, res_last_d;
  sli_pkg::status_e res_status_q, res_status_d;
  logic signed [sli_pkg::ValueW-1:0] res_elem_q, res_elem_d;
  logic [sli_pkg::CountW-1:0] res_count_q, res_count_d;
  logic [CntW+sli_pkg::CountW-1:0] count_ext;

  sli_pkg::cell_ctrl_t ctrl;
  logic signed [sli_pkg::ValueW-1:0] entry_w [DEPTH];
  logic [DEPTH-1:0] gt_w, ge_w, eq_w;
  logic found;

  assign found = |eq_w;
  assign busy  = state_q != sli_pkg::StIdle;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                              gt_left;
    logic signed [sli_pkg::ValueW-1:0] entry_left, entry_right;
    if (i == 0) begin : g_first
      assign gt_left    = 1'b0;
      assign entry_left = ctrl.value;
    end else begin : g_mid
      assign gt_left    = gt_w[i-1];
      assign entry_left = entry_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_lastc
      assign entry_right = entry_w[i];
    end else begin : g_nlast
      assign entry_right = entry_w[i+1];
    end
    sli_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .gt_left_i     (gt_left),
      .entry_left_i  (entry_left),
      .entry_right_i (entry_right),
      .entry_head_i  (entry_w[0]),
      .entry_o       (entry_w[i]),
      .gt_o          (gt_w[i]),
      .ge_o          (ge_w[i]),
      .eq_o          (eq_w[i])
    );
  end

  assign count_ext = {{sli_pkg::CountW{1'b0}}, count_d};

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rd_d         = rd_q;
    value_d      = value_q;
    found_any_d  = found_any_q;
    ctrl.op      = sli_pkg::CellHold;
    ctrl.value   = value_q;
    res_valid_d  = 1'b0;
    res_status_d = sli_pkg::StatusOk;
    res_elem_d   = '0;
    res_last_d   = 1'b1;
    case (state_q)
      sli_pkg::StIdle: begin
        ctrl.value = value_i;
        if (start) begin
          case (sli_pkg::mode_e'(mode_i))
            sli_pkg::ModeInsert: begin
              res_valid_d = 1'b1;
              if (count_q == Full) begin
                res_status_d = sli_pkg::StatusFull;
              end else begin
                ctrl.op = sli_pkg::CellInsert;
                count_d = count_q + One;
              end
            end
            sli_pkg::ModeDelOne: begin
              res_valid_d = 1'b1;
              if (found) begin
                ctrl.op = sli_pkg::CellShift;
                count_d = count_q - One;
              end else begin
                res_status_d = sli_pkg::StatusNotFound;
              end
            end
            sli_pkg::ModeDelAll: begin
              value_d     = value_i;
              found_any_d = 1'b0;
              state_d     = sli_pkg::StDelAll;
            end
            sli_pkg::ModeReadOut: begin
              if (count_q == '0) begin
                res_valid_d  = 1'b1;
                res_status_d = sli_pkg::StatusEmpty;
              end else begin
                rd_d    = '0;
                state_d = sli_pkg::StRead;
              end
            end
            default: state_d = sli_pkg::StIdle;
          endcase
        end
      end
      sli_pkg::StDelAll: begin
        if (found) begin
          ctrl.op     = sli_pkg::CellShift;
          count_d     = count_q - One;
          found_any_d = 1'b1;
        end else begin
          res_valid_d  = 1'b1;
          res_status_d = found_any_q ? sli_pkg::StatusOk : sli_pkg::StatusNotFound;
          state_d      = sli_pkg::StIdle;
        end
      end
      sli_pkg::StRead: begin
        ctrl.op     = sli_pkg::CellRotate;
        res_valid_d = 1'b1;
        res_elem_d  = entry_w[0];
        res_last_d  = rd_q == (count_q - One);
        rd_d        = rd_q + One;
        if (res_last_d) begin
          state_d = sli_pkg::StIdle;
        end
      end
      default: state_d = sli_pkg::StIdle;
    endcase
    res_count_d = count_ext[sli_pkg::CountW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sli_pkg::StIdle;
      count_q     <= '0;
      rd_q        <= '0;
      found_any_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_q        <= rd_d;
      found_any_q <= found_any_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q      <= value_d;
    res_status_q <= res_status_d;
    res_elem_q   <= res_elem_d;
    res_last_q   <= res_last_d;
    res_count_q  <= res_count_d;
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign element_o      = res_elem_q;
  assign last_o         = res_last_q;
  assign count_o        = res_count_q;

endmodule
